>>> hw/rtl/sorted_table_binary_search_assert.svh
// Assertion macros for the sorted table binary search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
// Checks that an implication holds at every clock edge out of reset.
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks a plain condition at every clock edge out of reset.
`define STBS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

>>> hw/rtl/stbs_pkg.sv
// Shared types and codes for the sorted table binary search block.
`default_nettype none
package stbs_pkg;
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LD_RD  = 6'b000010,
    ST_LD_CMP = 6'b000100,
    ST_SR_PRB = 6'b001000,
    ST_SR_CMP = 6'b010000,
    ST_SR_DON = 6'b100000
  } state_t;
endpackage
`default_nettype wire

>>> hw/rtl/stbs_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module stbs_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// A load word (command 0) inserts its value into a table kept in ascending
// order and gives no result; loads into a full table are dropped. A search
// word (command 1) runs a binary search over all loaded entries and gives one
// result word with found and position, position being 0 when not found.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The input stalls while a word is being worked on.
// A load moves each entry larger than the new value up one place, reading
// it and writing it back through the single table memory. A search probes
// by addressing the memory in ST_SR_PRB and comparing the registered read
// data in ST_SR_CMP, then gives its result from ST_SR_DON before the next
// word is taken.
// A finished result sits in the output register; if the receiver stalls it,
// the block may take and work on the next word, but holds that word's result
// until the output register is free.
// Synchronous reset empties the table at once; no clearing pass is needed.
`default_nettype none
`include "sorted_table_binary_search_assert.svh"
module sorted_table_binary_search #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic [9:0]       out_position
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = CW + 1;

  stbs_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic signed [IW-1:0]   low_r, low_nxt, high_r, high_nxt;
  logic signed [IW-1:0]   mid_r, mid_nxt, sum;
  logic                   hit_r, hit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [9:0]             out_position_r, out_position_nxt;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata, rdata;
  logic                   accept;

  stbs_ram #(.W(VALUE_WIDTH), .D(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != stbs_pkg::ST_IDLE);
  assign sum = low_r + high_r;

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    idx_nxt          = idx_r;
    key_nxt          = key_r;
    low_nxt          = low_r;
    high_nxt         = high_r;
    mid_nxt          = mid_r;
    hit_nxt          = hit_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    we               = 1'b0;
    waddr            = idx_r[AW-1:0];
    wdata            = key_r;
    raddr            = AW'(idx_r - CW'(1));
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (accept) begin
          key_nxt = VALUE_WIDTH'(in_value);
          if (in_command == stbs_pkg::CMD_SEARCH) begin
            low_nxt   = '0;
            high_nxt  = IW'(count_r) - IW'(1);
            state_nxt = stbs_pkg::ST_SR_PRB;
          end else if (count_r != CW'(CAPACITY)) begin
            idx_nxt   = count_r;
            count_nxt = count_r + CW'(1);
            state_nxt = stbs_pkg::ST_LD_RD;
          end
        end
      end
      stbs_pkg::ST_LD_RD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          state_nxt = stbs_pkg::ST_IDLE;
        end else begin
          state_nxt = stbs_pkg::ST_LD_CMP;
        end
      end
      stbs_pkg::ST_LD_CMP: begin
        we = 1'b1;
        if (rdata > key_r) begin
          wdata     = rdata;
          idx_nxt   = idx_r - CW'(1);
          state_nxt = stbs_pkg::ST_LD_RD;
        end else begin
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      stbs_pkg::ST_SR_PRB: begin
        mid_nxt = sum >>> 1;
        raddr   = AW'(sum >>> 1);
        if (low_r > high_r) begin
          hit_nxt   = 1'b0;
          state_nxt = stbs_pkg::ST_SR_DON;
        end else begin
          state_nxt = stbs_pkg::ST_SR_CMP;
        end
      end
      stbs_pkg::ST_SR_CMP: begin
        if (rdata == key_r) begin
          hit_nxt   = 1'b1;
          state_nxt = stbs_pkg::ST_SR_DON;
        end else begin
          if (key_r > rdata) begin
            low_nxt = mid_r + IW'(1);
          end else begin
            high_nxt = mid_r - IW'(1);
          end
          state_nxt = stbs_pkg::ST_SR_PRB;
        end
      end
      stbs_pkg::ST_SR_DON: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = hit_r;
          out_position_nxt = hit_r ? 10'(mid_r) : 10'd0;
          state_nxt        = stbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stbs_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r          <= idx_nxt;
    key_r          <= key_nxt;
    low_r          <= low_nxt;
    high_r         <= high_nxt;
    mid_r          <= mid_nxt;
    hit_r          <= hit_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  `STBS_CHECK(a_count_range, count_r <= CW'(CAPACITY), "entry count beyond capacity")
  `STBS_ASSERT(a_search_busy, (accept && in_command == stbs_pkg::CMD_SEARCH) |=> in_stall, "search did not start")
  `STBS_ASSERT(a_result_src, $rose(out_valid_r) |-> $past(state_r == stbs_pkg::ST_SR_DON), "result without search")
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Testbench for the sorted table binary search block with a self-checking search predictor.
`default_nettype none
module testbench;
  localparam int CAP = 1024;
  localparam longint CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire logic   in_stall;
  logic        in_command = stbs_pkg::CMD_LOAD;
  logic [31:0] in_value = '0;
  wire logic   out_valid;
  logic        out_stall = 1'b0;
  wire logic   out_found;
  wire logic [9:0] out_position;

  typedef struct packed {
    logic       found;
    logic [9:0] position;
  } hit_t;

  logic [31:0] table_vals[$];
  hit_t        pending_hits[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_cycles = 0;
  bit          quiet_out = 1'b0;

  sorted_table_binary_search i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_value(in_value), .out_valid(out_valid),
    .out_stall(out_stall), .out_found(out_found), .out_position(out_position)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keeps the table sorted on insert, placing a value after any equal ones as the block does.
  function automatic void table_load(logic [31:0] v);
    int i;
    if (table_vals.size() >= CAP) return;
    i = 0;
    while (i < table_vals.size() && table_vals[i] <= v) i++;
    table_vals.insert(i, v);
  endfunction

  function automatic hit_t table_search(logic [31:0] key);
    hit_t h;
    int lo, hi, mid;
    h = '0;
    lo = 0;
    hi = table_vals.size() - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (table_vals[mid] == key) begin
        h.found = 1'b1;
        h.position = mid[9:0];
        break;
      end else if (key > table_vals[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return h;
  endfunction

  task automatic send_word(logic cmd, logic [31:0] v, bit no_gap = 1'b0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == stbs_pkg::CMD_LOAD) table_load(v);
    else pending_hits.push_back(table_search(v));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (table_vals.size() > 0 && $urandom_range(0, 2) != 0)
      return table_vals[$urandom_range(0, table_vals.size() - 1)] + $urandom_range(0, 1);
    return $urandom();
  endfunction

  task automatic test_empty_and_extremes();
    send_word(stbs_pkg::CMD_SEARCH, 32'h0);
    send_word(stbs_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
    send_word(stbs_pkg::CMD_LOAD, 32'h0);
    send_word(stbs_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    send_word(stbs_pkg::CMD_LOAD, 32'h8000_0000);
    send_word(stbs_pkg::CMD_LOAD, 32'h8000_0000);
    send_word(stbs_pkg::CMD_LOAD, 32'h5555_5555);
    send_word(stbs_pkg::CMD_SEARCH, 32'h0);
    send_word(stbs_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
    send_word(stbs_pkg::CMD_SEARCH, 32'h8000_0000);
    send_word(stbs_pkg::CMD_SEARCH, 32'h5555_5555);
    send_word(stbs_pkg::CMD_SEARCH, 32'hAAAA_AAAA);
    send_word(stbs_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_mix(int n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) send_word(stbs_pkg::CMD_LOAD, $urandom());
      else send_word(stbs_pkg::CMD_SEARCH, pick_key());
    end
  endtask

  task automatic test_backpressure();
    hold_req <= !hold_req;
    repeat (8) send_word(stbs_pkg::CMD_SEARCH, pick_key(), 1'b1);
    idle_input();
    wait (hold_req == hold_ack && hold_cycles == 0);
  endtask

  // Loads many small random values back to back and searches small keys with the receiver ready.
  task automatic test_dense_values();
    quiet_out = 1'b1;
    repeat (30) send_word(stbs_pkg::CMD_LOAD, $urandom_range(0, 40), 1'b1);
    repeat (20) send_word(stbs_pkg::CMD_SEARCH, $urandom_range(0, 42), 1'b1);
    idle_input();
    quiet_out = 1'b0;
  endtask

  always @(posedge clk) begin
    int g;
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 300;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else begin
      g = $urandom_range(0, 99);
      out_stall <= (g < 25);
    end
  end

  always @(posedge clk) begin
    hit_t exp_hit;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result word with no search pending");
        errors++;
      end else begin
        exp_hit = pending_hits.pop_front();
        if (out_found !== exp_hit.found) begin
          $error("found: expected %0d, actual %0d", exp_hit.found, out_found);
          errors++;
        end
        if (out_position !== exp_hit.position) begin
          $error("position: expected %0d, actual %0d", exp_hit.position, out_position);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_extremes();
    test_random_mix(200);
    test_backpressure();
    test_random_mix(200);
    test_dense_values();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
